// ===== hw/rtl/cpc_pkg.sv =====
// shared types and constants of the console i/o port controller
package cpc_pkg;

  localparam int NUM_PORTS = 3;

  localparam logic [6:0] LATCH_MASK    = 7'h7F;
  localparam logic [7:0] SCTRL_MASK    = 8'hF8;
  localparam logic [7:0] TX_RESET      = 8'hFF;
  localparam logic [7:0] TX_RESET_LAST = 8'hFB;
  localparam logic [7:0] VER_OVERSEAS  = 8'h80;
  localparam logic [7:0] VER_PAL       = 8'h40;
  localparam logic [7:0] VER_NO_EXP    = 8'h20;

  typedef enum logic [2:0] {
    KIND_UNMAPPED,
    KIND_VERSION,
    KIND_DATA,
    KIND_DIR,
    KIND_TX,
    KIND_SCTRL
  } kind_t;

  typedef enum logic [1:0] {
    CFG_OVERSEAS  = 2'd0,
    CFG_PAL       = 2'd1,
    CFG_EXPANSION = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    kind_t      kind;
    logic [1:0] port;
  } access_t;

  typedef struct packed {
    logic overseas;
    logic pal;
    logic expansion;
  } cfg_t;

  typedef logic [2:0][6:0] pins_t;

endpackage

// ===== hw/rtl/cpc_decode.sv =====
// offset decoder: register kind and port index of a bus request
module cpc_decode (
  input  logic [3:0]       reg_offset,
  output cpc_pkg::access_t access
);
  import cpc_pkg::*;

  access_t raw;

  always_comb begin
    raw.kind = KIND_UNMAPPED;
    raw.port = 2'd0;
    unique case (reg_offset)
      4'd0: raw.kind = KIND_VERSION;
      4'd1: begin raw.kind = KIND_DATA; raw.port = 2'd0; end
      4'd2: begin raw.kind = KIND_DATA; raw.port = 2'd1; end
      4'd3: begin raw.kind = KIND_DATA; raw.port = 2'd2; end
      4'd4: begin raw.kind = KIND_DIR; raw.port = 2'd0; end
      4'd5: begin raw.kind = KIND_DIR; raw.port = 2'd1; end
      4'd6: begin raw.kind = KIND_DIR; raw.port = 2'd2; end
      4'd7: begin raw.kind = KIND_TX; raw.port = 2'd0; end
      4'd10: begin raw.kind = KIND_TX; raw.port = 2'd1; end
      4'd13: begin raw.kind = KIND_TX; raw.port = 2'd2; end
      4'd9: begin raw.kind = KIND_SCTRL; raw.port = 2'd0; end
      4'd12: begin raw.kind = KIND_SCTRL; raw.port = 2'd1; end
      4'd15: begin raw.kind = KIND_SCTRL; raw.port = 2'd2; end
      default: raw.kind = KIND_UNMAPPED;
    endcase
  end

  // ports that are not built act as unmapped offsets
  always_comb begin
    access = raw;
    if (raw.kind != KIND_UNMAPPED && raw.kind != KIND_VERSION &&
        int'(raw.port) >= NUM_PORTS) begin
      access.kind = KIND_UNMAPPED;
      access.port = 2'd0;
    end
  end

endmodule

// ===== hw/rtl/cpc_regfile.sv =====
// per-port register file with pin latch refresh and read mux
module cpc_regfile (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             func,
  input  cpc_pkg::access_t access,
  input  logic [7:0]       write_data,
  input  cpc_pkg::pins_t   pins,
  input  logic [2:0]       drive_mask,
  input  cpc_pkg::cfg_t    cfg,
  output logic [7:0]       read_data,
  output logic             unmapped
);
  import cpc_pkg::*;

  logic [7:0] port_data        [NUM_PORTS];
  logic [7:0] port_direction   [NUM_PORTS];
  logic [7:0] port_tx_data     [NUM_PORTS];
  logic [7:0] port_serial_ctrl [NUM_PORTS];
  logic [6:0] pin_latch        [NUM_PORTS];

  logic [7:0] port_data_next        [NUM_PORTS];
  logic [7:0] port_direction_next   [NUM_PORTS];
  logic [7:0] port_tx_data_next     [NUM_PORTS];
  logic [7:0] port_serial_ctrl_next [NUM_PORTS];
  logic [6:0] pin_latch_next        [NUM_PORTS];

  logic refresh;

  always_comb begin
    logic [6:0] dir7;
    logic [6:0] v;
    dir7 = '0;
    v = '0;
    port_data_next        = port_data;
    port_direction_next   = port_direction;
    port_tx_data_next     = port_tx_data;
    port_serial_ctrl_next = port_serial_ctrl;
    pin_latch_next        = pin_latch;
    refresh   = 1'b0;
    read_data = 8'h00;
    unmapped  = 1'b0;

    if (en && func) begin
      unique case (access.kind)
        KIND_DATA: begin
          port_data_next[access.port] = write_data;
          refresh = 1'b1;
        end
        KIND_DIR: begin
          port_direction_next[access.port] = write_data;
          refresh = 1'b1;
        end
        KIND_TX:    port_tx_data_next[access.port] = write_data;
        KIND_SCTRL: port_serial_ctrl_next[access.port] = write_data & SCTRL_MASK;
        default: ;
      endcase
    end else if (en && access.kind == KIND_DATA) begin
      refresh = 1'b1;
    end

    // output bits from data, input bits from driven pins or held
    if (refresh) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        dir7 = port_direction_next[i][6:0];
        v = (pin_latch[i] & ~dir7) | (port_data_next[i][6:0] & dir7);
        if (drive_mask[i]) begin
          v = (v & dir7) | (pins[i] & ~dir7);
        end
        pin_latch_next[i] = v & LATCH_MASK;
      end
    end

    if (!func) begin
      unique case (access.kind)
        KIND_VERSION: begin
          read_data = (cfg.overseas ? VER_OVERSEAS : 8'h00) |
                      (cfg.pal ? VER_PAL : 8'h00) |
                      (cfg.expansion ? 8'h00 : VER_NO_EXP);
        end
        KIND_DATA: begin
          read_data = {port_direction_next[access.port][7],
                       pin_latch_next[access.port]};
        end
        KIND_DIR:   read_data = port_direction[access.port];
        KIND_TX:    read_data = port_tx_data[access.port];
        KIND_SCTRL: read_data = port_serial_ctrl[access.port];
        KIND_UNMAPPED: begin
          read_data = 8'h00;
          unmapped  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        port_data[i]        <= 8'h00;
        port_direction[i]   <= 8'h00;
        port_tx_data[i]     <= (NUM_PORTS > 2 && i == NUM_PORTS - 1) ? TX_RESET_LAST
                                                                     : TX_RESET;
        port_serial_ctrl[i] <= 8'h00;
        pin_latch[i]        <= LATCH_MASK;
      end
    end else if (en) begin
      port_data        <= port_data_next;
      port_direction   <= port_direction_next;
      port_tx_data     <= port_tx_data_next;
      port_serial_ctrl <= port_serial_ctrl_next;
      pin_latch        <= pin_latch_next;
    end
  end

endmodule

// ===== hw/rtl/console_io_port_controller_core.sv =====
// top level of the console i/o port controller
// Each request is one bus read or write at a 4-bit register offset, carried with the
// external pin levels and drive mask that hold for that access. A request is taken into
// an input register; when it moves on, it is decoded and applied to the per-port register
// file, and its reply (read byte and unmapped flag) lands in an output register. One
// request is accepted per cycle while the output side is not stalled; a request passes
// through the input register, then the output register. A stalled reply holds the output
// register while one more request waits in the input register.
module console_io_port_controller_core (
  input  logic       clk,
  input  logic       rst,
  // request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       func,
  input  logic [3:0] reg_offset,
  input  logic [7:0] write_data,
  input  logic [6:0] pins_a,
  input  logic [6:0] pins_b,
  input  logic [6:0] pins_c,
  input  logic [2:0] drive_mask,
  // reply channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       unmapped,
  // configuration writes
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic       cfg_data
);
  import cpc_pkg::*;

  // input register
  logic       s0_valid;
  logic       s0_func;
  logic [3:0] s0_offset;
  logic [7:0] s0_wdata;
  pins_t      s0_pins;
  logic [2:0] s0_drive;

  cfg_t       cfg;
  access_t    access;
  logic       advance;
  logic       accept;
  logic [7:0] rd_comb;
  logic       unm_comb;

  // input stage moves on whenever the reply register is free or being drained
  assign advance  = s0_valid && (!out_valid || out_ready);
  assign in_ready = !s0_valid || !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (accept) begin
      s0_valid <= 1'b1;
    end else if (advance) begin
      s0_valid <= 1'b0;
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      s0_func    <= func;
      s0_offset  <= reg_offset;
      s0_wdata   <= write_data;
      s0_pins    <= {pins_c, pins_b, pins_a};
      s0_drive   <= drive_mask;
    end
  end

  // configuration flags, an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OVERSEAS:  cfg.overseas  <= cfg_data;
        CFG_PAL:       cfg.pal       <= cfg_data;
        CFG_EXPANSION: cfg.expansion <= cfg_data;
        default: ;
      endcase
    end
  end

  cpc_decode u_decode (
    .reg_offset (s0_offset),
    .access     (access)
  );

  cpc_regfile u_regfile (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .func       (s0_func),
    .access     (access),
    .write_data (s0_wdata),
    .pins       (s0_pins),
    .drive_mask (s0_drive),
    .cfg        (cfg),
    .read_data  (rd_comb),
    .unmapped   (unm_comb)
  );

  // reply register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data <= rd_comb;
      unmapped  <= unm_comb;
    end
  end

endmodule

// ===== hw/rtl/cpc_checker.sv =====
// port-level checks of the console i/o port controller
module cpc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_data,
  input logic       unmapped
);

  // a stalled reply holds
  a_reply_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(unmapped))
    else $error("stalled reply changed");

  // an unmapped read always returns zero
  a_unmapped_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && unmapped |-> read_data == 8'h00)
    else $error("unmapped reply carries data");

  // an empty reply side never blocks requests
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request stalled with empty reply register");

  // an accepted request is followed by a valid reply on the output
  a_reply_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("reply missing after accepted request");

endmodule

bind console_io_port_controller_core cpc_checker u_checker (.*);

// ===== dv/cpc_access_checker.sv =====
// checker for the console i/o port controller: predicts each reply and compares it
module cpc_access_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       func,
  input  logic [3:0] reg_offset,
  input  logic [7:0] write_data,
  input  logic [6:0] pins_a,
  input  logic [6:0] pins_b,
  input  logic [6:0] pins_c,
  input  logic [2:0] drive_mask,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] read_data,
  input  logic       unmapped,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic       cfg_data,
  output int         errors,
  output int         pending
);
  import cpc_pkg::*;

  typedef struct packed {
    logic [7:0] read_data;
    logic       unmapped;
  } reply_t;

  logic [7:0] data_q  [NUM_PORTS];
  logic [7:0] dir_q   [NUM_PORTS];
  logic [7:0] tx_q    [NUM_PORTS];
  logic [7:0] sctrl_q [NUM_PORTS];
  logic [6:0] latch_q [NUM_PORTS];
  cfg_t       cfg_q;
  reply_t     replies_due[$];
  int         err_total = 0;

  // output bits come from data, input bits from the pins of a driven port
  function automatic void refresh_latches(pins_t pins, logic [2:0] mask);
    logic [6:0] dir7;
    logic [6:0] v;
    for (int i = 0; i < NUM_PORTS; i++) begin
      dir7 = dir_q[i][6:0];
      v = (latch_q[i] & ~dir7) | (data_q[i][6:0] & dir7);
      if (mask[i]) v = (v & dir7) | (pins[i] & ~dir7);
      latch_q[i] = v;
    end
  endfunction

  function automatic reply_t access_register_file(logic wr, logic [3:0] off, logic [7:0] wd,
                                                  pins_t pins, logic [2:0] mask);
    kind_t  k;
    int     p;
    reply_t r;
    k = KIND_UNMAPPED;
    p = 0;
    r = '0;
    case (off)
      4'd0: k = KIND_VERSION;
      4'd1, 4'd2, 4'd3: begin
        k = KIND_DATA;
        p = int'(off) - 1;
      end
      4'd4, 4'd5, 4'd6: begin
        k = KIND_DIR;
        p = int'(off) - 4;
      end
      4'd7, 4'd10, 4'd13: begin
        k = KIND_TX;
        p = (int'(off) - 7) / 3;
      end
      4'd9, 4'd12, 4'd15: begin
        k = KIND_SCTRL;
        p = (int'(off) - 9) / 3;
      end
      default: k = KIND_UNMAPPED;
    endcase
    // ports beyond the configured count decode as holes
    if (k != KIND_UNMAPPED && k != KIND_VERSION && p >= NUM_PORTS) k = KIND_UNMAPPED;

    if (wr) begin
      case (k)
        KIND_DATA: begin
          data_q[p] = wd;
          refresh_latches(pins, mask);
        end
        KIND_DIR: begin
          dir_q[p] = wd;
          refresh_latches(pins, mask);
        end
        KIND_TX:    tx_q[p] = wd;
        KIND_SCTRL: sctrl_q[p] = wd & SCTRL_MASK;
        default: ;
      endcase
    end else begin
      case (k)
        KIND_VERSION:
          r.read_data = (cfg_q.overseas ? VER_OVERSEAS : 8'h00) |
                        (cfg_q.pal ? VER_PAL : 8'h00) |
                        (cfg_q.expansion ? 8'h00 : VER_NO_EXP);
        KIND_DATA: begin
          refresh_latches(pins, mask);
          r.read_data = {dir_q[p][7], latch_q[p]};
        end
        KIND_DIR:   r.read_data = dir_q[p];
        KIND_TX:    r.read_data = tx_q[p];
        KIND_SCTRL: r.read_data = sctrl_q[p];
        default:    r.unmapped = 1'b1;
      endcase
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        data_q[i]  = '0;
        dir_q[i]   = '0;
        sctrl_q[i] = '0;
        latch_q[i] = LATCH_MASK;
        tx_q[i]    = (NUM_PORTS > 2 && i == NUM_PORTS - 1) ? TX_RESET_LAST : TX_RESET;
      end
      cfg_q = '0;
      replies_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_OVERSEAS:  cfg_q.overseas = cfg_data;
          CFG_PAL:       cfg_q.pal = cfg_data;
          CFG_EXPANSION: cfg_q.expansion = cfg_data;
          default: ;
        endcase
      end
      // replies first: a reply can never belong to a request taken at the same edge
      if (out_valid && out_ready) begin
        got = {read_data, unmapped};
        if (replies_due.size() == 0) begin
          err_total++;
          if (err_total <= 10)
            $display("%0t: reply with no request outstanding: read_data %h unmapped %b",
                     $time, got.read_data, got.unmapped);
        end else begin
          want = replies_due.pop_front();
          if (got.read_data !== want.read_data || got.unmapped !== want.unmapped) begin
            err_total++;
            if (err_total <= 10)
              $display("%0t: reply mismatch: read_data exp %h got %h, unmapped exp %b got %b",
                       $time, want.read_data, got.read_data, want.unmapped, got.unmapped);
          end
        end
      end
      if (in_valid && in_ready)
        replies_due.push_back(access_register_file(func, reg_offset, write_data,
                                                   {pins_c, pins_b, pins_a}, drive_mask));
    end
    pending <= replies_due.size();
    errors  <= err_total;
  end

endmodule

// ===== dv/tb_top.sv =====
// testbench top for the console i/o port controller: stimulus, flow control and verdict
module tb_top;
  import cpc_pkg::*;

  // access kinds and register offsets of the bus map
  localparam logic       ACC_READ    = 1'b0;
  localparam logic       ACC_WRITE   = 1'b1;
  localparam logic [3:0] OFF_VERSION = 4'd0;
  localparam logic [3:0] OFF_DATA_A  = 4'd1;
  localparam logic [3:0] OFF_DATA_B  = 4'd2;
  localparam logic [3:0] OFF_DATA_C  = 4'd3;
  localparam logic [3:0] OFF_DIR_A   = 4'd4;
  localparam logic [3:0] OFF_DIR_C   = 4'd6;
  localparam logic [3:0] OFF_TX_A    = 4'd7;
  localparam logic [3:0] OFF_HOLE_A  = 4'd8;
  localparam logic [3:0] OFF_TX_B    = 4'd10;
  localparam logic [3:0] OFF_HOLE_B  = 4'd11;
  localparam logic [3:0] OFF_SCTRL_B = 4'd12;
  localparam logic [3:0] OFF_TX_C    = 4'd13;
  localparam logic [3:0] OFF_HOLE_C  = 4'd14;
  localparam logic [3:0] OFF_SCTRL_C = 4'd15;

  // flow control and run length knobs
  localparam int HOLD_CYCLES    = 60;    // long receiver hold-off to back the block up
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake before giving up
  localparam int PHASE_ITEMS    = 140;   // random requests per configuration phase
  localparam int BURST_ITEMS    = 24;    // back-to-back requests during the hold-off

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic       func;
  logic [3:0] reg_offset;
  logic [7:0] write_data;
  logic [6:0] pins_a;
  logic [6:0] pins_b;
  logic [6:0] pins_c;
  logic [2:0] drive_mask;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] read_data;
  logic       unmapped;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic       cfg_data;
  int         errors;
  int         pending;

  // knobs shared between the stimulus and the receiver
  bit sender_idle   = 1'b1;
  bit rx_idle       = 1'b1;
  bit hold_off_req  = 1'b0;

  always #5 clk = ~clk;

  console_io_port_controller_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .reg_offset (reg_offset),
    .write_data (write_data),
    .pins_a     (pins_a),
    .pins_b     (pins_b),
    .pins_c     (pins_c),
    .drive_mask (drive_mask),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_data  (read_data),
    .unmapped   (unmapped),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  cpc_access_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .reg_offset (reg_offset),
    .write_data (write_data),
    .pins_a     (pins_a),
    .pins_b     (pins_b),
    .pins_c     (pins_c),
    .drive_mask (drive_mask),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_data  (read_data),
    .unmapped   (unmapped),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending)
  );

  // offer one request and hold it until the block takes it; valid stays high on return
  // so a following request can go out back to back
  task automatic send_req(logic f, logic [3:0] off, logic [7:0] wd,
                          logic [6:0] pa, logic [6:0] pb, logic [6:0] pc, logic [2:0] dm);
    in_valid   <= 1'b1;
    func       <= f;
    reg_offset <= off;
    write_data <= wd;
    pins_a     <= pa;
    pins_b     <= pb;
    pins_c     <= pc;
    drive_mask <= dm;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // random access, biased toward the data and direction ports where the latch lives
  task automatic send_random();
    logic [3:0] off;
    logic [7:0] wd;
    if ($urandom_range(0, 1) == 0) off = 4'($urandom_range(OFF_DATA_A, OFF_DIR_C));
    else off = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 7))
      0:       wd = 8'h00;
      1:       wd = 8'hFF;
      default: wd = 8'($urandom);
    endcase
    send_req(1'($urandom_range(0, 1)), off, wd, 7'($urandom), 7'($urandom), 7'($urandom),
             3'($urandom));
  endtask

  // random requests with sender gaps; gaps only in every other stretch of 32
  task automatic run_random(int count);
    for (int k = 0; k < count; k++) begin
      send_random();
      if (sender_idle && ((k / 32) % 2 == 0) && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  endtask

  // stop offering and wait until every reply is back, then idle as slack
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg_reg(cfg_idx_t idx, logic val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // only called while the block is idle
  task automatic set_cfg(cfg_t c);
    write_cfg_reg(CFG_OVERSEAS, c.overseas);
    write_cfg_reg(CFG_PAL, c.pal);
    write_cfg_reg(CFG_EXPANSION, c.expansion);
    cfg_we <= 1'b0;
  endtask

  // reply side: random stall bursts, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // watchdog: any handshake on either channel resets the count
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    cfg_t phase_cfg;
    rst        = 1'b1;
    in_valid   = 1'b0;
    func       = ACC_READ;
    reg_offset = OFF_VERSION;
    write_data = '0;
    pins_a     = '0;
    pins_b     = '0;
    pins_c     = '0;
    drive_mask = '0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_OVERSEAS;
    cfg_data   = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_cfg(cfg_t'(3'b000));

    // directed: version with no expansion, holes, ignored writes, reset values
    send_req(ACC_READ,  OFF_VERSION, 8'h00, 7'h00, 7'h00, 7'h00, 3'b000);
    send_req(ACC_READ,  OFF_HOLE_A,  8'h00, 7'h00, 7'h00, 7'h00, 3'b000);
    send_req(ACC_READ,  OFF_HOLE_B,  8'hFF, 7'h7F, 7'h7F, 7'h7F, 3'b111);
    send_req(ACC_READ,  OFF_HOLE_C,  8'h00, 7'h00, 7'h00, 7'h00, 3'b000);
    send_req(ACC_WRITE, OFF_VERSION, 8'hFF, 7'h7F, 7'h7F, 7'h7F, 3'b111);
    send_req(ACC_WRITE, OFF_HOLE_B,  8'hFF, 7'h00, 7'h00, 7'h00, 3'b000);
    send_req(ACC_READ,  OFF_TX_A,    8'h00, 7'h00, 7'h00, 7'h00, 3'b000);
    send_req(ACC_READ,  OFF_TX_C,    8'h00, 7'h00, 7'h00, 7'h00, 3'b000);
    send_req(ACC_READ,  OFF_SCTRL_B, 8'h00, 7'h00, 7'h00, 7'h00, 3'b000);
    // port a all outputs, direction bit 7 shows up in data reads
    send_req(ACC_WRITE, OFF_DIR_A,   8'hFF, 7'h00, 7'h00, 7'h00, 3'b000);
    send_req(ACC_WRITE, OFF_DATA_A,  8'hAA, 7'h55, 7'h00, 7'h00, 3'b001);
    send_req(ACC_READ,  OFF_DATA_A,  8'h00, 7'h00, 7'h00, 7'h00, 3'b111);
    // port b all inputs: driven pins land, undriven port keeps the held value
    send_req(ACC_READ,  OFF_DATA_B,  8'h00, 7'h7F, 7'h00, 7'h7F, 3'b111);
    send_req(ACC_READ,  OFF_DATA_B,  8'h00, 7'h00, 7'h7F, 7'h00, 3'b000);
    // port c split direction
    send_req(ACC_WRITE, OFF_DIR_C,   8'h0F, 7'h00, 7'h00, 7'h00, 3'b000);
    send_req(ACC_WRITE, OFF_DATA_C,  8'h00, 7'h00, 7'h00, 7'h7F, 3'b100);
    send_req(ACC_READ,  OFF_DATA_C,  8'h00, 7'h00, 7'h00, 7'h00, 3'b000);
    send_req(ACC_READ,  OFF_DIR_C,   8'h00, 7'h00, 7'h00, 7'h00, 3'b000);
    // serial control drops its low three bits, tx data takes all eight
    send_req(ACC_WRITE, OFF_SCTRL_C, 8'hFF, 7'h00, 7'h00, 7'h00, 3'b000);
    send_req(ACC_READ,  OFF_SCTRL_C, 8'h00, 7'h00, 7'h00, 7'h00, 3'b000);
    send_req(ACC_WRITE, OFF_TX_B,    8'h00, 7'h00, 7'h00, 7'h00, 3'b000);
    send_req(ACC_READ,  OFF_TX_B,    8'h00, 7'h00, 7'h00, 7'h00, 3'b000);
    send_req(ACC_WRITE, OFF_DATA_A,  8'h00, 7'h7F, 7'h7F, 7'h7F, 3'b111);
    send_req(ACC_READ,  OFF_DATA_A,  8'h00, 7'h7F, 7'h7F, 7'h7F, 3'b111);
    send_req(ACC_READ,  OFF_DIR_A,   8'h00, 7'h00, 7'h00, 7'h00, 3'b000);

    // receiver holds off while requests keep coming, so the input side has to stall
    hold_off_req = 1'b1;
    for (int k = 0; k < BURST_ITEMS; k++) send_random();
    run_random(PHASE_ITEMS - BURST_ITEMS);
    drain();

    // phases with all flags set, each flag alone and a random setting; the last one runs without gaps or stalls
    for (int ph = 1; ph <= 5; ph++) begin
      case (ph)
        1:       phase_cfg = cfg_t'(3'b111);
        2:       phase_cfg = cfg_t'(3'b100);
        3:       phase_cfg = cfg_t'(3'b010);
        4:       phase_cfg = cfg_t'(3'b001);
        default: phase_cfg = cfg_t'(3'($urandom));
      endcase
      if (ph == 5) begin
        sender_idle = 1'b0;
        rx_idle     = 1'b0;
      end
      set_cfg(phase_cfg);
      run_random(PHASE_ITEMS);
      drain();
    end

    if (errors == 0 && pending == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule
